FILE: design/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, fixed-point constants and the arctangent table of the
// Euler-angle to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

	// field widths
	localparam int ANGLE_W = 16;
	localparam int QUAT_W  = 16;

	// cordic depth, capped at the table length
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_RUN    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
		: CORDIC_STAGES;

	// datapath widths: half angle in Q.30, cordic vector in Q.30, sin/cos in Q.16
	localparam int AEXT_W = 34;
	localparam int Z_W    = 33;
	localparam int X_W    = 33;
	localparam int SC_W   = 18;
	localparam int PA_W   = 2 * SC_W;
	localparam int PB_W   = PA_W + SC_W;
	localparam int SUM_W  = PB_W + 1;
	localparam int RND_W  = SUM_W - 34;

	localparam logic signed [AEXT_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [AEXT_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [X_W-1:0]    GAIN_Q30    = 33'sd652032874;
	localparam logic signed [QUAT_W-1:0] Q_ONE       = 16'sd16384;

	// round(atan(2^-i) * 2^30)
	localparam logic signed [Z_W-1:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
		33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
		33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
		33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
		33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
		33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
		33'sd1024,      33'sd512,       33'sd256,       33'sd128
	};

endpackage

`default_nettype wire

FILE: design/e2q_angle_if.sv
// ----------------------------------------------------------------------------
// e2q_angle_if
// Valid/ready channel carrying one set of roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2q_angle_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [e2q_pkg::ANGLE_W-1:0]     roll_angle;
	logic signed [e2q_pkg::ANGLE_W-1:0]     pitch_angle;
	logic signed [e2q_pkg::ANGLE_W-1:0]     yaw_angle;

	modport source (output valid, output roll_angle, output pitch_angle,
		output yaw_angle, input ready);
	modport sink (input valid, input roll_angle, input pitch_angle,
		input yaw_angle, output ready);
endinterface

`default_nettype wire

FILE: design/e2q_quat_if.sv
// ----------------------------------------------------------------------------
// e2q_quat_if
// Valid/ready channel carrying one unit quaternion in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2q_quat_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [e2q_pkg::QUAT_W-1:0]     quat_w;
	logic signed [e2q_pkg::QUAT_W-1:0]     quat_x;
	logic signed [e2q_pkg::QUAT_W-1:0]     quat_y;
	logic signed [e2q_pkg::QUAT_W-1:0]     quat_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface

`default_nettype wire

FILE: design/euler_to_quaternion.sv
// An accepted transaction passes the fold stage, one stage per cordic iteration,
//   rounding, two product stages and the output register; CORDIC_RUN is 16 here.
// Throughput: one transaction per cycle while the skid entry is empty, set by
//   the fully unrolled cordic lanes.
// A two-entry output buffer keeps ready registered and lets input flow while
//   a result waits; ready drops only when both are full. Reset clears valid bits.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Converts ZYX Euler angles (Q3.13 rad) to a saturated Q1.14 unit quaternion
// through three parallel half-angle cordic lanes and a product pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion (
	input  wire logic       clk,
	input  wire logic       arst_n,
	e2q_angle_if.sink       angles,
	e2q_quat_if.source      quat
);

	localparam int RUN  = e2q_pkg::CORDIC_RUN;
	localparam int LAST = RUN + 3;

	// pipeline valid bits: 0 fold, 1..RUN cordic, RUN+1 round, RUN+2/3 products
	logic v_s [0:LAST];
	logic adv;

	// cordic lanes: 0 roll, 1 pitch, 2 yaw
	logic signed [e2q_pkg::X_W-1:0] cx_s [0:RUN][0:2];
	logic signed [e2q_pkg::X_W-1:0] cy_s [0:RUN][0:2];
	logic signed [e2q_pkg::Z_W-1:0] cz_s [0:RUN][0:2];
	logic                           flip_s [0:RUN][0:2];

	logic signed [e2q_pkg::SC_W-1:0] sin_s [0:2];
	logic signed [e2q_pkg::SC_W-1:0] cos_s [0:2];

	// pair products and the yaw terms carried alongside
	logic signed [e2q_pkg::PA_W-1:0] pa_s [0:3];
	logic signed [e2q_pkg::SC_W-1:0] sy_s;
	logic signed [e2q_pkg::SC_W-1:0] cyw_s;
	logic signed [e2q_pkg::PB_W-1:0] pb_s [0:7];

	// output buffer
	logic                             out_valid_q;
	logic                             skid_valid_q;
	logic signed [e2q_pkg::QUAT_W-1:0] out_q  [0:3];
	logic signed [e2q_pkg::QUAT_W-1:0] skid_q [0:3];
	logic signed [e2q_pkg::QUAT_W-1:0] res    [0:3];
	logic                             push;
	logic                             pop;

	logic signed [e2q_pkg::ANGLE_W-1:0] ang_in [0:2];

	// round a Q.48 sum to Q.14 and saturate to plus or minus one
	function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q14(
		input logic signed [e2q_pkg::SUM_W-1:0] v
	);
		logic signed [e2q_pkg::SUM_W-1:0] t;
		logic signed [e2q_pkg::RND_W-1:0] r;
		t = v + (e2q_pkg::SUM_W'(1) <<< 33);
		r = t[e2q_pkg::SUM_W-1:34];
		if (r > e2q_pkg::RND_W'(e2q_pkg::Q_ONE))
			return e2q_pkg::Q_ONE;
		else if (r < -e2q_pkg::RND_W'(e2q_pkg::Q_ONE))
			return -e2q_pkg::Q_ONE;
		else
			return r[e2q_pkg::QUAT_W-1:0];
	endfunction

	// pipeline moves whenever the skid entry is free
	assign adv          = !skid_valid_q;
	assign angles.ready = adv;
	assign ang_in[0]    = angles.roll_angle;
	assign ang_in[1]    = angles.pitch_angle;
	assign ang_in[2]    = angles.yaw_angle;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++)
				v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= angles.valid;
			for (int k = 1; k <= LAST; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	// fold stage: half angle in Q.30, folded into plus or minus pi/2
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				logic signed [e2q_pkg::AEXT_W-1:0] a;
				a = {{2{ang_in[l][e2q_pkg::ANGLE_W-1]}}, ang_in[l], 16'h0000};
				cx_s[0][l] <= e2q_pkg::GAIN_Q30;
				cy_s[0][l] <= '0;
				if (a > e2q_pkg::HALF_PI_Q30) begin
					cz_s[0][l]   <= e2q_pkg::Z_W'(a - e2q_pkg::PI_Q30);
					flip_s[0][l] <= 1'b1;
				end else if (a < -e2q_pkg::HALF_PI_Q30) begin
					cz_s[0][l]   <= e2q_pkg::Z_W'(a + e2q_pkg::PI_Q30);
					flip_s[0][l] <= 1'b1;
				end else begin
					cz_s[0][l]   <= e2q_pkg::Z_W'(a);
					flip_s[0][l] <= 1'b0;
				end
			end
		end
	end

	// cordic rotation stages, one iteration per register stage
	for (genvar i = 0; i < RUN; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 3; l++) begin
					flip_s[i+1][l] <= flip_s[i][l];
					if (!cz_s[i][l][e2q_pkg::Z_W-1]) begin
						cx_s[i+1][l] <= cx_s[i][l] - (cy_s[i][l] >>> i);
						cy_s[i+1][l] <= cy_s[i][l] + (cx_s[i][l] >>> i);
						cz_s[i+1][l] <= cz_s[i][l] - e2q_pkg::ATAN_Q30[i];
					end else begin
						cx_s[i+1][l] <= cx_s[i][l] + (cy_s[i][l] >>> i);
						cy_s[i+1][l] <= cy_s[i][l] - (cx_s[i][l] >>> i);
						cz_s[i+1][l] <= cz_s[i][l] + e2q_pkg::ATAN_Q30[i];
					end
				end
			end
		end
	end

	// undo the fold and round Q.30 to Q.16
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				logic signed [e2q_pkg::AEXT_W-1:0] c;
				logic signed [e2q_pkg::AEXT_W-1:0] s;
				if (flip_s[RUN][l]) begin
					c = e2q_pkg::AEXT_W'(8192) - e2q_pkg::AEXT_W'(cx_s[RUN][l]);
					s = e2q_pkg::AEXT_W'(8192) - e2q_pkg::AEXT_W'(cy_s[RUN][l]);
				end else begin
					c = e2q_pkg::AEXT_W'(cx_s[RUN][l]) + e2q_pkg::AEXT_W'(8192);
					s = e2q_pkg::AEXT_W'(cy_s[RUN][l]) + e2q_pkg::AEXT_W'(8192);
				end
				cos_s[l] <= c[14 +: e2q_pkg::SC_W];
				sin_s[l] <= s[14 +: e2q_pkg::SC_W];
			end
		end
	end

	// roll by pitch products
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s[0] <= cos_s[0] * cos_s[1];
			pa_s[1] <= sin_s[0] * sin_s[1];
			pa_s[2] <= sin_s[0] * cos_s[1];
			pa_s[3] <= cos_s[0] * sin_s[1];
			cyw_s   <= cos_s[2];
			sy_s    <= sin_s[2];
		end
	end

	// times the yaw terms
	always_ff @(posedge clk) begin
		if (adv) begin
			pb_s[0] <= pa_s[0] * cyw_s;
			pb_s[1] <= pa_s[1] * sy_s;
			pb_s[2] <= pa_s[2] * cyw_s;
			pb_s[3] <= pa_s[3] * sy_s;
			pb_s[4] <= pa_s[3] * cyw_s;
			pb_s[5] <= pa_s[2] * sy_s;
			pb_s[6] <= pa_s[0] * sy_s;
			pb_s[7] <= pa_s[1] * cyw_s;
		end
	end

	// sum, round and saturate each component
	always_comb begin
		res[0] = to_q14(e2q_pkg::SUM_W'(pb_s[0]) + e2q_pkg::SUM_W'(pb_s[1]));
		res[1] = to_q14(e2q_pkg::SUM_W'(pb_s[2]) - e2q_pkg::SUM_W'(pb_s[3]));
		res[2] = to_q14(e2q_pkg::SUM_W'(pb_s[4]) + e2q_pkg::SUM_W'(pb_s[5]));
		res[3] = to_q14(e2q_pkg::SUM_W'(pb_s[6]) - e2q_pkg::SUM_W'(pb_s[7]));
	end

	assign push = adv && v_s[LAST];
	assign pop  = out_valid_q && quat.ready;

	// output register and skid entry control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign quat.valid  = out_valid_q;
	assign quat.quat_w = out_q[0];
	assign quat.quat_x = out_q[1];
	assign quat.quat_y = out_q[2];
	assign quat.quat_z = out_q[3];

endmodule

`default_nettype wire
